// ===== rtl/core/dcc_pq_pkg.sv =====
// Shared types, codes and constants of the DCC packet queue transmitter.
// No dependencies; used by dcc_pq_out_buf and dcc_packet_queue_transmitter.
package dcc_pq_pkg;

	localparam int DEF_SLOTS     = 5;
	localparam int DEF_MAX_BYTES = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;

	localparam logic [5:0] RST_NORMAL_PREAMBLE = 6'd16;
	localparam logic [5:0] RST_LONG_PREAMBLE   = 6'd22;
	localparam logic [7:0] RST_ONE_HALF        = 8'd116;
	localparam logic [7:0] RST_ZERO_HALF       = 8'd200;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_IDLE  = 2'd2;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_STORED   = 3'd1;
	localparam logic [2:0] ST_QUEUED   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_STOPPED  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_RUNNING   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVICE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PRE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF = 3'd5;

	localparam int PKT_LEN = 3;
	localparam logic [7:0] IDLE_PKT [PKT_LEN]  = '{8'hFF, 8'h00, 8'hFF};
	localparam logic [7:0] RESET_PKT [PKT_LEN] = '{8'h00, 8'h00, 8'h00};

	typedef enum logic [1:0] {
		SRC_WRITTEN,
		SRC_IDLE,
		SRC_RESET
	} src_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] message_id;
		logic       line_bit;
		logic [7:0] half_period;
		logic       tx_started;
		logic       tx_completed;
		logic [7:0] event_message_id;
		logic       event_user;
		logic       event_long_preamble;
		logic       idle_timer_restart;
	} result_t;

	function automatic logic [7:0] pkt_byte(input src_t src, input logic [1:0] pos);
		logic [7:0] b;
		b = 8'h00;
		if (pos < 2'(PKT_LEN)) begin
			b = (src == SRC_IDLE) ? IDLE_PKT[pos] : RESET_PKT[pos];
		end
		return b;
	endfunction

endpackage

// ===== rtl/core/dcc_pq_out_buf.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on dcc_pq_pkg for result_t.
module dcc_pq_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dcc_pq_pkg::result_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dcc_pq_pkg::result_t out_data
);
	import dcc_pq_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= skid_valid_q && in_valid;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (in_valid) begin
					skid_data_q <= in_data;
				end
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end else if (in_valid) begin
			skid_data_q <= in_data;
		end
	end

endmodule

// ===== rtl/core/dcc_packet_queue_transmitter.sv =====
// DCC packet transmitter with a slot queue: slot store, line coder, config registers.
// Depends on dcc_pq_pkg and dcc_pq_out_buf.
//
// channel  handshake            payload
// input    s_tvalid/s_tready    s_tdata, s_tlast, s_tuser
// result   m_tvalid/m_tready    m_tdata, m_tuser
// config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while s_tready is high; each item's result is registered in the output buffer.
// The byte store is read ahead into a registered read port at the next start-bit address.
// Reset clears control state only; the byte store needs no clearing pass.
// A stalled result moves to a skid register; input stalls only when both are full.
module dcc_packet_queue_transmitter #(
	parameter int SLOTS     = dcc_pq_pkg::DEF_SLOTS,
	parameter int MAX_BYTES = dcc_pq_pkg::DEF_MAX_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // data_byte
	input  logic                              s_tlast,
	input  logic [2:0]                        s_tuser,   // operation[1:0], user_provided
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// message_id, line_bit, half_period, tx_started, tx_completed,
	// event_message_id, event_user, event_long_preamble, idle_timer_restart, pad
	output logic [31:0]                       m_tdata,
	output logic [2:0]                        m_tuser,   // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dcc_pq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcc_pq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dcc_pq_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW    = $clog2(MAX_BYTES + 1);
	localparam int DEPTH = SLOTS * MAX_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int AW1   = AW + 1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_START,
		PH_DATA,
		PH_STOP
	} phase_t;

	logic       acc;
	logic       cfg_we;
	logic [1:0] op;
	logic       last;
	logic       user;
	result_t    res;
	result_t    res_out;

	logic       running_q, running_d;
	logic       service_q, service_d;
	logic [5:0] npre_q, npre_d;
	logic [5:0] lpre_q, lpre_d;
	logic [7:0] one_hp_q, one_hp_d;
	logic [7:0] zero_hp_q, zero_hp_d;

	logic [SLOTS-1:0] in_use_q, in_use_d;
	logic [SLOTS-1:0] long_q, long_d;
	logic [SLOTS-1:0] user_q, user_d;
	logic [7:0]       id_q [SLOTS];
	logic [LW-1:0]    len_q [SLOTS];
	src_t             src_q [SLOTS];

	phase_t        phase_q, phase_d;
	logic [SW-1:0] tx_slot_q, tx_slot_d;
	logic [5:0]    pre_q, pre_d;
	logic [LW-1:0] byte_pos_q, byte_pos_d;
	logic [3:0]    bits_q, bits_d;
	logic [7:0]    shift_q, shift_d;
	logic [7:0]    next_id_q, next_id_d;
	logic          fill_active_q, fill_active_d;
	logic [SW-1:0] fill_slot_q, fill_slot_d;
	logic [LW-1:0] fill_count_q, fill_count_d;
	logic          fill_discard_q, fill_discard_d;

	logic [7:0]    cur_id_q;
	logic          cur_user_q;
	logic          cur_long_q;
	logic [LW-1:0] cur_len_q;
	src_t          cur_src_q;
	logic          pick_en;

	logic          commit_en;
	logic [SW-1:0] commit_slot;
	logic [LW-1:0] commit_len;
	src_t          commit_src;

	logic [7:0]     mem [DEPTH];
	logic [7:0]     rd_q;
	logic           mem_we;
	logic [AW1-1:0] mem_waddr;
	logic [7:0]     mem_wdata;
	logic [AW1-1:0] rd_addr;
	logic           rd_en;

	logic          free_found;
	logic [SW-1:0] free_idx;
	logic          any_used;
	logic [SW-1:0] first_idx;

	logic [SW-1:0] slot;
	logic [LW-1:0] cnt;
	logic          bit_v;

	assign op        = s_tuser[1:0];
	assign user      = s_tuser[2];
	assign last      = s_tlast;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		any_used   = 1'b0;
		first_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i] &&
			    !(fill_active_q && !fill_discard_q && fill_slot_q == SW'(i))) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
			if (in_use_q[i]) begin
				any_used  = 1'b1;
				first_idx = SW'(i);
			end
		end
	end

	always_comb begin
		running_d      = running_q;
		service_d      = service_q;
		npre_d         = npre_q;
		lpre_d         = lpre_q;
		one_hp_d       = one_hp_q;
		zero_hp_d      = zero_hp_q;
		in_use_d       = in_use_q;
		long_d         = long_q;
		user_d         = user_q;
		phase_d        = phase_q;
		tx_slot_d      = tx_slot_q;
		pre_d          = pre_q;
		byte_pos_d     = byte_pos_q;
		bits_d         = bits_q;
		shift_d        = shift_q;
		next_id_d      = next_id_q;
		fill_active_d  = fill_active_q;
		fill_slot_d    = fill_slot_q;
		fill_count_d   = fill_count_q;
		fill_discard_d = fill_discard_q;
		pick_en        = 1'b0;
		commit_en      = 1'b0;
		commit_slot    = free_idx;
		commit_len     = LW'(PKT_LEN);
		commit_src     = SRC_WRITTEN;
		mem_we         = 1'b0;
		mem_waddr      = '0;
		mem_wdata      = s_tdata;
		slot           = fill_active_q ? fill_slot_q : free_idx;
		cnt            = fill_active_q ? fill_count_q : '0;
		bit_v          = 1'b1;
		res            = '0;

		if (acc) begin
			case (op)
				OP_WRITE: begin
					if (!running_q) begin
						res.status     = ST_STOPPED;
						fill_active_d  = !last;
						fill_discard_d = !last;
						fill_count_d   = '0;
					end else if (fill_active_q && fill_discard_q) begin
						if (last) begin
							fill_active_d  = 1'b0;
							fill_discard_d = 1'b0;
						end
					end else if (!fill_active_q && !free_found) begin
						res.status     = ST_FULL;
						fill_active_d  = !last;
						fill_discard_d = !last;
						fill_count_d   = '0;
					end else begin
						fill_slot_d = slot;
						if (cnt >= LW'(MAX_BYTES)) begin
							res.status     = ST_TOO_LONG;
							fill_active_d  = !last;
							fill_discard_d = !last;
							fill_count_d   = '0;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = AW1'(slot) * AW1'(MAX_BYTES) + AW1'(cnt);
							if (last) begin
								commit_en      = 1'b1;
								commit_slot    = slot;
								commit_len     = cnt + 1'b1;
								commit_src     = SRC_WRITTEN;
								in_use_d[slot] = 1'b1;
								long_d[slot]   = service_q;
								user_d[slot]   = user;
								res.status     = ST_QUEUED;
								res.message_id = next_id_q;
								next_id_d      = next_id_q + 8'd1;
								fill_active_d  = 1'b0;
								fill_discard_d = 1'b0;
								fill_count_d   = '0;
							end else begin
								res.status     = ST_STORED;
								fill_active_d  = 1'b1;
								fill_discard_d = 1'b0;
								fill_count_d   = cnt + 1'b1;
							end
						end
					end
				end
				OP_IDLE: begin
					if (!running_q) begin
						res.status = ST_STOPPED;
					end else if (!free_found) begin
						res.status = ST_FULL;
					end else begin
						commit_en          = 1'b1;
						commit_slot        = free_idx;
						commit_len         = LW'(PKT_LEN);
						commit_src         = service_q ? SRC_RESET : SRC_IDLE;
						in_use_d[free_idx] = 1'b1;
						long_d[free_idx]   = 1'b0;
						user_d[free_idx]   = 1'b0;
						res.status         = ST_QUEUED;
						res.message_id     = next_id_q;
						next_id_d          = next_id_q + 8'd1;
					end
				end
				OP_TICK: begin
					if (running_q) begin
						unique case (phase_q)
							PH_IDLE: begin
								if (any_used) begin
									pick_en                 = 1'b1;
									tx_slot_d               = first_idx;
									res.tx_started          = 1'b1;
									res.event_message_id    = id_q[first_idx];
									res.event_user          = user_q[first_idx];
									res.event_long_preamble = long_q[first_idx];
									res.idle_timer_restart  = ($countones(in_use_q) <= 1);
									pre_d   = long_q[first_idx] ? lpre_q : npre_q;
									phase_d = PH_PRE;
								end
							end
							PH_PRE: begin
								if (pre_q <= 6'd1) begin
									pre_d      = '0;
									byte_pos_d = '0;
									phase_d    = PH_START;
								end else begin
									pre_d = pre_q - 6'd1;
								end
							end
							PH_START: begin
								bit_v  = 1'b0;
								bits_d = 4'd8;
								if (byte_pos_q < LW'(MAX_BYTES)) begin
									shift_d = (cur_src_q == SRC_WRITTEN) ? rd_q :
									          pkt_byte(cur_src_q, byte_pos_q[1:0]);
								end else begin
									shift_d = 8'h00;
								end
								byte_pos_d = byte_pos_q + 1'b1;
								phase_d    = PH_DATA;
							end
							PH_DATA: begin
								if (bits_q <= 4'd1) begin
									phase_d = (byte_pos_q >= cur_len_q) ? PH_STOP : PH_START;
								end
								bit_v   = shift_q[7];
								shift_d = {shift_q[6:0], 1'b0};
								bits_d  = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;
							end
							PH_STOP: begin
								res.tx_completed        = 1'b1;
								res.event_message_id    = cur_id_q;
								res.event_user          = cur_user_q;
								res.event_long_preamble = cur_long_q;
								in_use_d[tx_slot_q]     = 1'b0;
								phase_d                 = PH_IDLE;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
						res.line_bit    = bit_v;
						res.half_period = bit_v ? one_hp_q : zero_hp_q;
					end
				end
				default: begin
				end
			endcase
		end

		if (cfg_we) begin
			unique case (cfg_index)
				REG_RUNNING: begin
					if (!running_q && cfg_data[0]) begin
						phase_d    = PH_IDLE;
						tx_slot_d  = '0;
						pre_d      = '0;
						byte_pos_d = '0;
						bits_d     = '0;
						shift_d    = '0;
					end
					running_d = cfg_data[0];
				end
				REG_SERVICE:    service_d = cfg_data[0];
				REG_NORMAL_PRE: npre_d    = cfg_data[5:0];
				REG_LONG_PRE:   lpre_d    = cfg_data[5:0];
				REG_ONE_HALF:   one_hp_d  = cfg_data[7:0];
				REG_ZERO_HALF:  zero_hp_d = cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign rd_addr = AW1'(tx_slot_d) * AW1'(MAX_BYTES) + AW1'(byte_pos_d);
	assign rd_en   = (byte_pos_d < LW'(MAX_BYTES));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr[AW-1:0]] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= 1'b0;
			service_q      <= 1'b0;
			npre_q         <= RST_NORMAL_PREAMBLE;
			lpre_q         <= RST_LONG_PREAMBLE;
			one_hp_q       <= RST_ONE_HALF;
			zero_hp_q      <= RST_ZERO_HALF;
			in_use_q       <= '0;
			long_q         <= '0;
			user_q         <= '0;
			phase_q        <= PH_IDLE;
			tx_slot_q      <= '0;
			pre_q          <= '0;
			byte_pos_q     <= '0;
			bits_q         <= '0;
			shift_q        <= '0;
			next_id_q      <= '0;
			fill_active_q  <= 1'b0;
			fill_slot_q    <= '0;
			fill_count_q   <= '0;
			fill_discard_q <= 1'b0;
		end else begin
			running_q      <= running_d;
			service_q      <= service_d;
			npre_q         <= npre_d;
			lpre_q         <= lpre_d;
			one_hp_q       <= one_hp_d;
			zero_hp_q      <= zero_hp_d;
			in_use_q       <= in_use_d;
			long_q         <= long_d;
			user_q         <= user_d;
			phase_q        <= phase_d;
			tx_slot_q      <= tx_slot_d;
			pre_q          <= pre_d;
			byte_pos_q     <= byte_pos_d;
			bits_q         <= bits_d;
			shift_q        <= shift_d;
			next_id_q      <= next_id_d;
			fill_active_q  <= fill_active_d;
			fill_slot_q    <= fill_slot_d;
			fill_count_q   <= fill_count_d;
			fill_discard_q <= fill_discard_d;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			id_q[commit_slot]  <= next_id_q;
			len_q[commit_slot] <= commit_len;
			src_q[commit_slot] <= commit_src;
		end
		if (pick_en) begin
			cur_id_q   <= id_q[first_idx];
			cur_user_q <= user_q[first_idx];
			cur_long_q <= long_q[first_idx];
			cur_len_q  <= len_q[first_idx];
			cur_src_q  <= src_q[first_idx];
		end
	end

	dcc_pq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tuser = res_out.status;
	assign m_tdata = {2'b00, res_out.idle_timer_restart, res_out.event_long_preamble,
	                  res_out.event_user, res_out.event_message_id, res_out.tx_completed,
	                  res_out.tx_started, res_out.half_period, res_out.line_bit,
	                  res_out.message_id};

	a_tx_slot_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> in_use_q[tx_slot_q])
		else $error("line coder active on a free slot");

	a_fill_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_active_q && !fill_discard_q) |-> !in_use_q[fill_slot_q])
		else $error("slot being filled is already committed");

	a_stop_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_TICK && running_q && phase_q == PH_STOP)
		|=> (!in_use_q[tx_slot_q] && phase_q == PH_IDLE))
		else $error("stop bit did not free the slot");

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule
